/* src/tse_pkg.sv */
// Shared types and constants of the totient sum engine.
// Depends on nothing; every other file of the block imports it.
package tse_pkg;

    // Working widths of the number path and of the running sum.
    localparam int VALUE_BITS = 16;
    localparam int SUM_BITS   = 40;

    // Fixed widths of the channel fields.
    localparam int NUMBER_W    = 16;
    localparam int TOTIENT_W   = 16;
    localparam int BATCH_SUM_W = 40;

    // Trial divisor width: p never exceeds 2^ceil(VALUE_BITS/2).
    localparam int P_BITS       = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS      = 2 * P_BITS;
    localparam int DIV_CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int ACC_BITS     = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // Queue between the front and the back.
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_DEPTH    = 2 ** QUEUE_PTR_BITS;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                batch_end;
    } tse_in_t;

    typedef struct packed {
        logic [TOTIENT_W-1:0]   totient;
        logic [BATCH_SUM_W-1:0] batch_sum;
        logic                   batch_done;
    } tse_out_t;

    // One classified job as it waits in the queue.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  trivial;
        logic                  batch_end;
    } job_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [VALUE_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

/* src/tse_divider.sv */
// Restoring divider of the totient sum engine, one quotient bit per cycle.
// Depends on tse_pkg for widths and the request and response structs.
module tse_divider
    import tse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]   rem_reg, rem_next;
    logic [VALUE_BITS-1:0]   quo_reg, quo_next;
    logic [VALUE_BITS-1:0]   divisor_reg, divisor_next;
    logic [VALUE_BITS:0]     partial;
    logic [VALUE_BITS:0]     diff;
    logic                    quo_bit;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        partial = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff    = partial - {1'b0, divisor_reg};
        quo_bit = ~diff[VALUE_BITS];
    end

    // Next state of the iteration.
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (req.start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next = quo_bit ? diff[VALUE_BITS-1:0] : partial[VALUE_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], quo_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* src/tse_front.sv */
// Front part of the totient sum engine: takes input transfers, classifies
// them and holds them in a short queue. Depends on tse_pkg.
module tse_front
    import tse_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  tse_in_t s_payload,
    output logic    job_valid,
    input  logic    job_ready,
    output job_t    job
);

    job_t                      q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   fill_reg, fill_next;
    logic                      push;
    logic                      pop;
    job_t                      incoming;

    // Classification: numbers below two need no trial division.
    always_comb begin
        incoming.value     = VALUE_BITS'(s_payload.number);
        incoming.trivial   = (incoming.value < VALUE_BITS'(2));
        incoming.batch_end = s_payload.batch_end;
    end

    assign s_ready   = (fill_reg != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign job_valid = (fill_reg != '0);
    assign job       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid & s_ready;
    assign pop       = job_valid & job_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

/* src/tse_back.sv */
// Back part of the totient sum engine: trial-division sequencer over the
// shared divider, batch sum and result register. Depends on tse_pkg.
module tse_back
    import tse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     job_valid,
    output logic     job_ready,
    input  job_t     job,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    output logic     m_valid,
    input  logic     m_ready,
    output tse_out_t m_payload
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_TEST  = 7'b0000010,
        ST_DIVR  = 7'b0000100,
        ST_DIVC  = 7'b0001000,
        ST_FINAL = 7'b0010000,
        ST_DIVF  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] rest_reg, rest_next;
    logic [VALUE_BITS-1:0] count_reg, count_next;
    logic [P_BITS-1:0]     p_reg, p_next;
    logic                  hit_reg, hit_next;
    logic                  last_reg, last_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    tse_out_t              out_data_reg, out_data_next;
    logic [SQ_BITS-1:0]    p_square;
    logic [ACC_BITS-1:0]   acc;
    logic [SUM_BITS-1:0]   sum_new;
    logic                  out_free;

    assign p_square = SQ_BITS'(p_reg) * SQ_BITS'(p_reg);
    assign out_free = ~out_valid_reg | m_ready;

    // Saturating batch sum including the current totient.
    always_comb begin
        acc     = ACC_BITS'(sum_reg) + ACC_BITS'(count_reg);
        sum_new = (acc > ACC_BITS'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(acc);
    end

    // Sequencer: strip each prime factor p from rest and apply
    // count -= count / p once per distinct prime.
    always_comb begin
        state_next       = state_reg;
        rest_next        = rest_reg;
        count_next       = count_reg;
        p_next           = p_reg;
        hit_next         = hit_reg;
        last_next        = last_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg & ~m_ready;
        out_data_next    = out_data_reg;
        job_ready        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = rest_reg;
        div_req.divisor  = VALUE_BITS'(p_reg);
        case (state_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    rest_next  = job.value;
                    count_next = job.value;
                    p_next     = P_BITS'(2);
                    hit_next   = 1'b0;
                    last_next  = job.batch_end;
                    state_next = job.trivial ? ST_EMIT : ST_TEST;
                end
            end
            ST_TEST: begin
                if (p_square > SQ_BITS'(rest_reg)) begin
                    state_next = ST_FINAL;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVR;
                end
            end
            ST_DIVR: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        rest_next = div_rsp.quotient;
                        if (!hit_reg) begin
                            hit_next         = 1'b1;
                            div_req.start    = 1'b1;
                            div_req.dividend = count_reg;
                            state_next       = ST_DIVC;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = div_rsp.quotient;
                        end
                    end else begin
                        p_next     = p_reg + 1'b1;
                        hit_next   = 1'b0;
                        state_next = ST_TEST;
                    end
                end
            end
            ST_DIVC: begin
                if (div_rsp.done) begin
                    count_next    = count_reg - div_rsp.quotient;
                    div_req.start = 1'b1;
                    state_next    = ST_DIVR;
                end
            end
            ST_FINAL: begin
                if (rest_reg > VALUE_BITS'(1)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = count_reg;
                    div_req.divisor  = rest_reg;
                    state_next       = ST_DIVF;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVF: begin
                if (div_rsp.done) begin
                    count_next = count_reg - div_rsp.quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next           = 1'b1;
                    out_data_next.totient    = TOTIENT_W'(count_reg);
                    out_data_next.batch_sum  = BATCH_SUM_W'(sum_new);
                    out_data_next.batch_done = last_reg;
                    sum_next                 = last_reg ? '0 : sum_new;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rest_reg     <= rest_next;
        count_reg    <= count_next;
        p_reg        <= p_next;
        hit_reg      <= hit_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_data_reg;

endmodule

/* src/totient_sum_engine.sv */
// Top level of the totient sum engine: front queue, back sequencer, divider.
// Depends on tse_pkg, tse_front, tse_back and tse_divider.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_valid / s_ready   tse_in_t  {number, batch_end}
//   m_        out        m_valid / m_ready   tse_out_t {totient, batch_sum, batch_done}
//
// Each number takes a series of divisions on the shared bit-serial divider:
// one per trial divisor up to sqrt(n), one per prime factor counted with
// multiplicity, one more per distinct prime.
// Reset is synchronous and active low; it clears the queue, sequencer and batch sum.
// The front queue holds two numbers, and a finished result waits in its output
// register while the back already works on the next number.
module totient_sum_engine
    import tse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tse_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output tse_out_t m_payload
);

    logic     job_valid;
    logic     job_ready;
    job_t     job;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Input transfers are classified and queued.
    tse_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // Totient computation, batch sum and result register.
    tse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Shared divider.
    tse_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

`ifndef SYNTHESIS
    // A division is never started while another is still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("division started while divider busy");

    // The back takes a new job only with the divider idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready) |-> !div_rsp.busy)
        else $error("job taken during a division");

    // A started division never completes in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> !div_rsp.done)
        else $error("division finished too early");

    // The input side stalls only when the queue holds work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> job_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule
